### src/cfp_pkg.sv
// package: constants, symbol table and types for the formula parser
package cfp_pkg;

  localparam int MaxTermsDef = 6;
  localparam int MaxTextDef = 255;
  localparam int TableEntriesDef = 105;
  localparam int SymbolCount = 105;
  localparam int AmtW = 17;
  localparam logic [7:0] ChargeElem = 8'd255;
  localparam logic [16:0] UnitAmount = 17'd128;
  localparam logic [8:0] AccLimit = 9'd511;
  localparam logic [8:0] IntLimit = 9'd256;

  localparam logic [7:0] ChStar = 8'h2A;
  localparam logic [7:0] ChPlus = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot = 8'h2E;
  localparam logic [7:0] ChBrack = 8'h5B;
  localparam logic [7:0] ChSpace = 8'h20;

  localparam string Symbols =
    {"H HeLiBeB C N O F NeNaMgAlSiP S ClArK CaScTiV CrMnFeCoNiCuZn",
     "GaGeAsSeBrKrRbSrY ZrNbMoTcRuRhPdAgCdInSnSbTeI XeCsBaLaCePrNd",
     "PmSmEuGdTbDyHoErTmYbLuHfTaW ReOsIrPtAuHgTlPbBiPoAtRnFrRaAcTh",
     "PaU NpPuAmCmBkCfEsFmMdNoLrKuNs"};

  typedef enum logic [2:0] {
    PhStart, PhSym, PhLetter, PhAmt0, PhInt, PhFrac, PhNote, PhError
  } phase_e;

  // controller -> datapath
  typedef struct packed {
    logic       take_char;
    logic       finish;
    logic       clear;
    logic       load_out;
    logic [2:0] emit_idx;
  } cfp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       is_error;
    logic [3:0] count;
  } cfp_stat_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    upcase = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [7:0] sym_char(input int i);
    sym_char = 8'(Symbols[i]);
  endfunction

  function automatic logic [6:0] find_pair(input logic [7:0] a, input logic [7:0] b,
                                           input int lim);
    logic [6:0] r;
    r = '0;
    for (int i = SymbolCount - 1; i >= 0; i--) begin
      if (i < lim && upcase(a) == sym_char(2 * i) && upcase(b) == upcase(sym_char(2 * i + 1)))
        r = 7'(i + 1);
    end
    find_pair = r;
  endfunction

  function automatic logic [6:0] find_single(input logic [7:0] a, input int lim);
    logic [6:0] r;
    r = '0;
    for (int i = SymbolCount - 1; i >= 0; i--) begin
      if (i < lim && upcase(a) == sym_char(2 * i) && sym_char(2 * i + 1) == ChSpace)
        r = 7'(i + 1);
    end
    find_single = r;
  endfunction

endpackage

### src/cfp_if.sv
// interfaces: input and result channels
interface cfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_text;
  modport source (output valid, character, end_of_text, input ready);
  modport sink (input valid, character, end_of_text, output ready);
endinterface

interface cfp_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         element;
  logic signed [16:0] amount;
  logic               is_solid;
  logic               is_error;
  logic [7:0]         error_position;
  logic               last_result;
  modport source (output valid, element, amount, is_solid, is_error, error_position,
                  last_result, input ready);
  modport sink (input valid, element, amount, is_solid, is_error, error_position,
                last_result, output ready);
endinterface

### src/chemical_formula_parser.sv
// top level: chemical formula parser
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid/ready   | character, end_of_text
//  out_ch  | out | valid/ready   | element, amount, is_solid, is_error, error_position, last_result
// one text character per cycle while in_ch is ready; after the terminator the datapath runs the
// sort passes (not waited for on an error), the controller leaves the sort wait and the result
// register is loaded; further results follow one per cycle while out_ch is ready
// input is not taken from the terminator until the last result is taken
// rst_ni clears all control state asynchronously; term store is not reset
module chemical_formula_parser #(
  parameter int MaxTerms = cfp_pkg::MaxTermsDef,
  parameter int MaxText = cfp_pkg::MaxTextDef,
  parameter int TableEntries = cfp_pkg::TableEntriesDef
) (
  input logic    clk_i,
  input logic    rst_ni,
  cfp_in_if.sink in_ch,
  cfp_out_if.source out_ch
);
  import cfp_pkg::*;

  cfp_cmd_t  cmd;   // controller commands
  cfp_stat_t stat;  // datapath status

  cfp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_eot_i(in_ch.end_of_text), .in_ready_o(in_ch.ready),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .stat_i(stat), .cmd_o(cmd)
  );

  cfp_datapath #(.MaxTerms(MaxTerms), .MaxText(MaxText), .TableEntries(TableEntries)) u_dp (
    .clk_i, .rst_ni, .char_i(in_ch.character), .cmd_i(cmd), .stat_o(stat),
    .element_o(out_ch.element), .amount_o(out_ch.amount), .is_solid_o(out_ch.is_solid),
    .is_error_o(out_ch.is_error), .error_position_o(out_ch.error_position),
    .last_result_o(out_ch.last_result)
  );
endmodule

### src/cfp_datapath.sv
// datapath: character parser, term store, sorter and result register
module cfp_datapath #(
  parameter int MaxTerms = cfp_pkg::MaxTermsDef,
  parameter int MaxText = cfp_pkg::MaxTextDef,
  parameter int TableEntries = cfp_pkg::TableEntriesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           char_i,
  input  cfp_pkg::cfp_cmd_t    cmd_i,
  output cfp_pkg::cfp_stat_t   stat_o,
  output logic [7:0]           element_o,
  output logic signed [16:0]   amount_o,
  output logic                 is_solid_o,
  output logic                 is_error_o,
  output logic [7:0]           error_position_o,
  output logic                 last_result_o
);
  import cfp_pkg::*;

  localparam int Lim = (TableEntries < SymbolCount) ? TableEntries : SymbolCount;
  localparam int CntW = $clog2(MaxTerms + 1);
  localparam int IdxW = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam logic [7:0] MaxTextV = 8'(MaxText);

  phase_e      phase_q, phase_d;
  logic [7:0]  pos_q, pos_d, held_q, held_d, cur_q, cur_d;
  logic [8:0]  acc_q, acc_d;
  logic [6:0]  hund_q, hund_d;
  logic [1:0]  dcnt_q, dcnt_d;
  logic        minus_q, minus_d, solid_q, solid_d, err_q, err_d;
  logic [7:0]  errpos_q, errpos_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]  el_q [MaxTerms];
  logic [16:0] am_q [MaxTerms];
  logic [7:0]  el_d [MaxTerms];
  logic [16:0] am_d [MaxTerms];
  logic        sorted_q;

  // one character step or the terminator step, written the way the text is scanned
  always_comb begin
    logic [7:0] c, p, pe;
    logic [6:0] idx;
    logic [16:0] a;
    logic digit, ok, dup, go_amt, go_sym;
    logic [12:0] v;
    phase_d = phase_q; pos_d = pos_q; held_d = held_q; cur_d = cur_q;
    acc_d = acc_q; hund_d = hund_q; dcnt_d = dcnt_q; minus_d = minus_q;
    solid_d = solid_q; err_d = err_q; errpos_d = errpos_q; cnt_d = cnt_q;
    el_d = el_q; am_d = am_q;
    c = char_i; p = pos_q + 8'd1;
    pe = (pos_q >= MaxTextV) ? MaxTextV : pos_q + 8'd1;
    idx = '0; a = '0; ok = 1'b0; dup = 1'b0; v = '0;
    go_amt = 1'b0; go_sym = 1'b0;
    digit = (c >= 8'h30 && c <= 8'h39);
    if (cmd_i.take_char && phase_q != PhNote && phase_q != PhError) begin
      if (pos_q >= MaxTextV) begin
        if (!err_q) begin err_d = 1'b1; errpos_d = MaxTextV; end
        phase_d = PhError;
      end else begin
        pos_d = p;
        case (phase_q)
          PhStart: if (c == ChStar) begin solid_d = 1'b1; phase_d = PhSym; end
                   else go_sym = 1'b1;
          PhSym: go_sym = 1'b1;
          PhLetter: begin
            idx = is_letter(c) ? find_pair(held_q, c, Lim) : 7'd0;
            if (idx != 0) begin
              cur_d = {1'b0, idx}; minus_d = 1'b0; acc_d = '0; hund_d = '0; dcnt_d = '0;
              phase_d = PhAmt0;
            end else begin
              idx = find_single(held_q, Lim);
              if (idx == 0) begin
                if (!err_q) begin err_d = 1'b1; errpos_d = pos_q; end
                phase_d = PhError;
              end else begin
                cur_d = {1'b0, idx}; minus_d = 1'b0; acc_d = '0; hund_d = '0; dcnt_d = '0;
                phase_d = PhAmt0;
                go_amt = 1'b1;
              end
            end
          end
          default: go_amt = 1'b1;
        endcase
        if (go_amt) begin
          if (phase_d == PhFrac && digit) begin
            if (dcnt_d == 2'd0) hund_d = 7'((c - 8'h30) * 8'd10);
            else if (dcnt_d == 2'd1) hund_d = hund_d + 7'(c - 8'h30);
            if (dcnt_d < 2'd2) dcnt_d = dcnt_d + 2'd1;
          end else if (phase_d != PhFrac && digit) begin
            v = 13'(acc_d) * 13'd10 + 13'(c - 8'h30);
            acc_d = (v > 13'(AccLimit)) ? AccLimit : v[8:0];
            phase_d = PhInt;
          end else if (phase_d != PhFrac && c == ChDot) begin
            phase_d = PhFrac;
          end else begin
            // close the term
            ok = 1'b1;
            if (phase_d == PhAmt0) a = UnitAmount;
            else begin
              a = 17'(acc_d) * 17'd128 + 17'(hund_d);
              if (acc_d > IntLimit || a == 0) ok = 1'b0;
            end
            if (minus_d) a = -a;
            for (int k = 0; k < MaxTerms; k++)
              if (k < cnt_q && el_q[k] == cur_d) dup = 1'b1;
            if (dup || cnt_q >= CntW'(MaxTerms)) ok = 1'b0;
            if (!ok) begin
              if (!err_q) begin err_d = 1'b1; errpos_d = p; end
              phase_d = PhError;
            end else begin
              el_d[cnt_q[IdxW-1:0]] = cur_d;
              am_d[cnt_q[IdxW-1:0]] = a;
              cnt_d = cnt_q + 1'b1;
              if (c == ChBrack) phase_d = PhNote;
              else go_sym = 1'b1;
            end
          end
        end
        if (go_sym) begin
          if (c == ChPlus || c == ChMinus) begin
            cur_d = ChargeElem; minus_d = (c == ChMinus);
            acc_d = '0; hund_d = '0; dcnt_d = '0; phase_d = PhAmt0;
          end else if (is_letter(c)) begin
            held_d = c; phase_d = PhLetter;
          end else begin
            if (!err_d) begin err_d = 1'b1; errpos_d = p; end
            phase_d = PhError;
          end
        end
      end
    end else if (cmd_i.finish) begin
      go_amt = 1'b0;
      case (phase_q)
        PhStart, PhSym: begin
          if (!err_q) begin err_d = 1'b1; errpos_d = pe; end
        end
        PhLetter, PhAmt0, PhInt, PhFrac: begin
          if (phase_q == PhLetter) begin
            idx = find_single(held_q, Lim);
            cur_d = {1'b0, idx}; minus_d = 1'b0; acc_d = '0; hund_d = '0;
          end
          if (phase_q == PhLetter && idx == 0) begin
            if (!err_q) begin err_d = 1'b1; errpos_d = pos_q; end
          end else begin
            ok = 1'b1;
            if (phase_q == PhLetter || phase_q == PhAmt0) a = UnitAmount;
            else begin
              a = 17'(acc_q) * 17'd128 + 17'(hund_q);
              if (acc_q > IntLimit || a == 0) ok = 1'b0;
            end
            if (minus_d) a = -a;
            for (int k = 0; k < MaxTerms; k++)
              if (k < cnt_q && el_q[k] == cur_d) dup = 1'b1;
            if (dup || cnt_q >= CntW'(MaxTerms)) ok = 1'b0;
            if (!ok) begin
              if (!err_q) begin err_d = 1'b1; errpos_d = pe; end
            end else begin
              el_d[cnt_q[IdxW-1:0]] = cur_d;
              am_d[cnt_q[IdxW-1:0]] = a;
              cnt_d = cnt_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // odd-even transposition sort: one pass per cycle after finish
  logic [CntW-1:0] pass_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart; pos_q <= '0; held_q <= '0; cur_q <= '0; acc_q <= '0;
      hund_q <= '0; dcnt_q <= '0; minus_q <= 1'b0; solid_q <= 1'b0; err_q <= 1'b0;
      errpos_q <= '0; cnt_q <= '0; pass_q <= '0; sorted_q <= 1'b0;
    end else if (cmd_i.clear) begin
      phase_q <= PhStart; pos_q <= '0; held_q <= '0; cur_q <= '0; acc_q <= '0;
      hund_q <= '0; dcnt_q <= '0; minus_q <= 1'b0; solid_q <= 1'b0; err_q <= 1'b0;
      errpos_q <= '0; cnt_q <= '0; pass_q <= '0; sorted_q <= 1'b0;
    end else if (cmd_i.take_char || cmd_i.finish) begin
      phase_q <= cmd_i.finish ? PhNote : phase_d;
      pos_q <= pos_d; held_q <= held_d; cur_q <= cur_d; acc_q <= acc_d;
      hund_q <= hund_d; dcnt_q <= dcnt_d; minus_q <= minus_d; solid_q <= solid_d;
      err_q <= err_d; errpos_q <= errpos_d; cnt_q <= cnt_d; pass_q <= '0;
      sorted_q <= 1'b0;
    end else if (!sorted_q && phase_q == PhNote && cmd_i.emit_idx == '0 && !cmd_i.load_out) begin
      pass_q <= pass_q + 1'b1;
      if (pass_q >= CntW'(MaxTerms)) sorted_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_char || cmd_i.finish) begin
      el_q <= el_d; am_q <= am_d;
    end else if (!sorted_q && phase_q == PhNote) begin
      for (int k = 0; k + 1 < MaxTerms; k++) begin
        if ((k % 2) == int'(pass_q[0]) && k + 1 < cnt_q && el_q[k] > el_q[k+1]) begin
          el_q[k] <= el_q[k+1]; el_q[k+1] <= el_q[k];
          am_q[k] <= am_q[k+1]; am_q[k+1] <= am_q[k];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      is_solid_o <= solid_q;
      is_error_o <= err_q;
      if (err_q) begin
        element_o <= '0; amount_o <= '0; error_position_o <= errpos_q; last_result_o <= 1'b1;
      end else begin
        element_o <= el_q[cmd_i.emit_idx[IdxW-1:0]];
        amount_o <= am_q[cmd_i.emit_idx[IdxW-1:0]];
        error_position_o <= '0;
        last_result_o <= (4'(cmd_i.emit_idx) + 4'd1 == 4'(cnt_q));
      end
    end
  end

  assign stat_o.is_error = err_q;
  assign stat_o.count = sorted_q ? 4'(cnt_q) : 4'd15;
endmodule

### src/cfp_ctrl.sv
// controller: text intake, sort wait and result sequencing
module cfp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_eot_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  cfp_pkg::cfp_stat_t  stat_i,
  output cfp_pkg::cfp_cmd_t   cmd_o
);
  import cfp_pkg::*;

  typedef enum logic [1:0] {StIn, StSort, StEmit, StWait} state_e;
  state_e     state_q;
  logic [2:0] idx_q;
  logic       ovalid_q;
  logic       acc;

  assign acc = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIn);
  assign out_valid_o = ovalid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.take_char = acc && !in_eot_i;
    cmd_o.finish = acc && in_eot_i;
    cmd_o.emit_idx = idx_q;
    cmd_o.load_out = (state_q == StEmit) && (!ovalid_q || out_ready_i);
    cmd_o.clear = (state_q == StWait) && out_ready_i;
    if (state_q == StSort) cmd_o.emit_idx = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIn; idx_q <= '0; ovalid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
      case (state_q)
        StIn: if (cmd_o.finish) begin state_q <= StSort; idx_q <= '0; end
        StSort: if (stat_i.is_error || stat_i.count != 4'd15) state_q <= StEmit;
        StEmit: if (cmd_o.load_out) begin
          if (stat_i.is_error || 4'(idx_q) + 4'd1 >= stat_i.count) state_q <= StWait;
          else idx_q <= idx_q + 3'd1;
        end
        StWait: if (out_ready_i) begin state_q <= StIn; idx_q <= '0; end
        default: state_q <= StIn;
      endcase
    end
  end
endmodule

### test/tb_cfp_checker.sv
// checker: predicts formula parser results from the accepted items and compares them
`timescale 1ns / 1ps

module tb_cfp_checker (
  input  logic    clk_i,
  input  logic    rst_ni,
  cfp_in_if       in_ch,
  cfp_out_if      out_ch,
  output int      mismatches_o,
  output int      waiting_o
);
  import cfp_pkg::*;

  localparam int Terms = 6;
  localparam int TextMax = 255;
  localparam int Entries = 105;

  typedef struct packed {
    logic [7:0]         element;
    logic signed [16:0] amount;
    logic               is_solid;
    logic               is_error;
    logic [7:0]         error_position;
    logic               last_result;
  } term_res_t;

  term_res_t parsed_q[$];

  int     pos;
  phase_e ph;
  logic [7:0] held;
  int     acc, hund, dcnt, cur;
  bit     minus, solid, err;
  int     err_pos;
  int     t_el[Terms];
  int     t_amt[Terms];
  int     t_cnt;

  function automatic logic [7:0] upper(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic bit alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic int pair_index(logic [7:0] a, logic [7:0] b);
    for (int i = 0; i < Entries; i++)
      if (upper(a) == Symbols[2*i] && upper(b) == upper(Symbols[2*i+1])) return i + 1;
    return 0;
  endfunction

  function automatic int single_index(logic [7:0] a);
    for (int i = 0; i < Entries; i++)
      if (upper(a) == Symbols[2*i] && Symbols[2*i+1] == ChSpace) return i + 1;
    return 0;
  endfunction

  task automatic clear_parse();
    pos = 0; ph = PhStart; held = 0; acc = 0; hund = 0; dcnt = 0; cur = 0;
    minus = 0; solid = 0; err = 0; err_pos = 0; t_cnt = 0;
    for (int k = 0; k < Terms; k++) begin
      t_el[k] = 0;
      t_amt[k] = 0;
    end
  endtask

  task automatic flag_error(int p);
    if (!err) begin
      err = 1;
      err_pos = p & 8'hFF;
    end
    ph = PhError;
  endtask

  task automatic open_term(int e, bit m);
    cur = e; minus = m; acc = 0; hund = 0; dcnt = 0; ph = PhAmt0;
  endtask

  task automatic close_term(int p, output bit ok);
    int amt;
    ok = 0;
    if (ph == PhAmt0) amt = 128;
    else begin
      if (acc > 256) begin flag_error(p); return; end
      amt = acc * 128 + hund;
      if (amt == 0) begin flag_error(p); return; end
    end
    if (minus) amt = -amt;
    for (int k = 0; k < t_cnt; k++)
      if (t_el[k] == cur) begin flag_error(p); return; end
    if (t_cnt >= Terms) begin flag_error(p); return; end
    t_el[t_cnt] = cur;
    t_amt[t_cnt] = amt;
    t_cnt++;
    ok = 1;
  endtask

  task automatic symbol_start(logic [7:0] c, int p);
    if (c == ChPlus) open_term(255, 0);
    else if (c == ChMinus) open_term(255, 1);
    else if (alpha(c)) begin
      held = c;
      ph = PhLetter;
    end else flag_error(p);
  endtask

  task automatic amount_digit(logic [7:0] c, int p);
    bit dig, ok;
    dig = c >= "0" && c <= "9";
    if (ph == PhFrac) begin
      if (dig) begin
        if (dcnt == 0) hund = (c - "0") * 10;
        else if (dcnt == 1) hund = hund + (c - "0");
        if (dcnt < 2) dcnt++;
        return;
      end
    end else begin
      if (dig) begin
        acc = acc * 10 + (c - "0");
        if (acc > 511) acc = 511;
        ph = PhInt;
        return;
      end
      if (c == ChDot) begin
        ph = PhFrac;
        return;
      end
    end
    close_term(p, ok);
    if (!ok) return;
    if (c == ChBrack) ph = PhNote;
    else symbol_start(c, p);
  endtask

  task automatic second_letter(logic [7:0] c, int p);
    int idx;
    if (alpha(c)) begin
      idx = pair_index(held, c);
      if (idx != 0) begin open_term(idx, 0); return; end
    end
    idx = single_index(held);
    if (idx == 0) begin flag_error(p - 1); return; end
    open_term(idx, 0);
    amount_digit(c, p);
  endtask

  // terminator: close the open term, then queue either the error or the sorted terms
  task automatic end_text();
    int pe, idx, n, te, ta;
    bit ok;
    int el[Terms];
    int am[Terms];
    term_res_t r;
    pe = (pos >= TextMax) ? TextMax : pos + 1;
    case (ph)
      PhStart, PhSym: flag_error(pe);
      PhLetter: begin
        idx = single_index(held);
        if (idx == 0) flag_error(pos);
        else begin
          open_term(idx, 0);
          close_term(pe, ok);
        end
      end
      PhAmt0, PhInt, PhFrac: close_term(pe, ok);
      default: ;
    endcase
    if (err) begin
      r = '{element: 0, amount: 0, is_solid: solid, is_error: 1,
            error_position: err_pos[7:0], last_result: 1};
      parsed_q.push_back(r);
    end else begin
      n = t_cnt;
      for (int k = 0; k < n; k++) begin el[k] = t_el[k]; am[k] = t_amt[k]; end
      for (int k = 0; k + 1 < n; k++)
        for (int l = 0; l + 1 < n - k; l++)
          if (el[l] > el[l+1]) begin
            te = el[l]; ta = am[l];
            el[l] = el[l+1]; am[l] = am[l+1];
            el[l+1] = te; am[l+1] = ta;
          end
      for (int k = 0; k < n; k++) begin
        r = '{element: el[k][7:0], amount: am[k][16:0], is_solid: solid, is_error: 0,
              error_position: 0, last_result: (k == n - 1)};
        parsed_q.push_back(r);
      end
    end
    clear_parse();
  endtask

  task automatic take_item(logic [7:0] c, logic eot);
    if (eot) begin
      end_text();
      return;
    end
    if (ph == PhNote || ph == PhError) return;
    if (pos >= TextMax) begin flag_error(TextMax); return; end
    pos++;
    case (ph)
      PhStart: begin
        if (c == ChStar) begin solid = 1; ph = PhSym; end
        else symbol_start(c, pos);
      end
      PhSym: symbol_start(c, pos);
      PhLetter: second_letter(c, pos);
      default: amount_digit(c, pos);
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    term_res_t want, got;
    if (!rst_ni) begin
      clear_parse();
      parsed_q.delete();
      mismatches_o <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{element: out_ch.element, amount: out_ch.amount, is_solid: out_ch.is_solid,
                is_error: out_ch.is_error, error_position: out_ch.error_position,
                last_result: out_ch.last_result};
        if (parsed_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = parsed_q.pop_front();
          if (got !== want) begin
            $display("%0t: expected %p, actual %p", $time, want, got);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) take_item(in_ch.character, in_ch.end_of_text);
    end
  end

  assign waiting_o = parsed_q.size();

endmodule

### test/tb_chemical_formula_parser.sv
// testbench top: formula text stimulus, clock, reset and verdict for the formula parser
`timescale 1ns / 1ps

module tb_chemical_formula_parser;
  import cfp_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   mismatches, waiting;
  int   burst_left = 0;
  int   sent = 0;

  cfp_in_if  in_ch ();
  cfp_out_if out_ch ();

  always #5 clk_i = ~clk_i;

  chemical_formula_parser dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  tb_cfp_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches_o(mismatches),
    .waiting_o   (waiting)
  );

  // receiver stall pattern: phases of always-ready, heavy stalls and light stalls
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(5, 60);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.character = 8'h00;
    in_ch.end_of_text = 1'b0;
    out_ch.ready = 1'b0;
  end

  // one item; valid drops only when a gap is inserted after the handshake
  task automatic send_item(logic [7:0] c, logic eot);
    in_ch.valid <= 1'b1;
    in_ch.character <= c;
    in_ch.end_of_text <= eot;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? 1000 : $urandom_range(1, 12);
      if ($urandom_range(0, 1)) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_formula(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    // character of the terminator is don't-care, so randomize it
    send_item(8'($urandom), 1'b1);
  endtask

  // random formula, not always well-formed, with optional solid marker, charge and note
  function automatic string random_formula();
    string s;
    int    n, e, used[int];
    logic [7:0] a, b;
    s = ($urandom_range(0, 4) == 0) ? "*" : "";
    n = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        s = {s, ($urandom_range(0, 1) ? "+" : "-")};
      end else begin
        e = $urandom_range(1, 105);
        if (used.exists(e) && $urandom_range(0, 3) != 0) e = $urandom_range(1, 105);
        used[e] = 1;
        a = Symbols[2*(e-1)];
        b = Symbols[2*(e-1)+1];
        if ($urandom_range(0, 3) == 0) a = a + 8'd32;
        s = {s, string'(a)};
        if (b != ChSpace) begin
          if ($urandom_range(0, 3) == 0 && b >= "a") b = b - 8'd32;
          s = {s, string'(b)};
        end
      end
      case ($urandom_range(0, 5))
        0: ;
        1: s = {s, $sformatf("%0d", $urandom_range(1, 9))};
        2: s = {s, $sformatf("%0d", $urandom_range(0, 300))};
        3: s = {s, $sformatf("%0d.%0d", $urandom_range(0, 256), $urandom_range(0, 999))};
        4: s = {s, $sformatf(".%0d", $urandom_range(0, 99))};
        default: s = {s, $sformatf("%0d.", $urandom_range(0, 20))};
      endcase
    end
    if ($urandom_range(0, 5) == 0) s = {s, "[aq", string'(8'($urandom_range(32, 126))), "]"};
    return s;
  endfunction

  function automatic string noise_text();
    string s;
    s = "";
    repeat ($urandom_range(0, 8)) s = {s, string'(8'($urandom_range(1, 255)))};
    return s;
  endfunction

  initial begin
    string longtxt;
    int    limit;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: plain, solid, fractions, charges, case, table fixups
    send_formula("H2O");
    send_formula("*NaCl");
    send_formula("Fe2.5O3.125");
    send_formula("cA1.05cl2");
    send_formula("+2-1.5");
    send_formula("-");
    send_formula("Pd1Ag.5");
    send_formula("CuSO4[hydrate]");
    send_formula("Ns256.99Ku.01");
    // error cases: bad symbol, bad char, empty texts, zero, too large, repeat, too many
    send_formula("Qz");
    send_formula("H1#");
    send_formula("");
    send_formula("*");
    send_formula("[note");
    send_formula("H0");
    send_formula("H.0");
    send_formula("H257");
    send_formula("H99999");
    send_formula("HeH2He");
    send_formula("HCNOFSP");
    send_formula("J");
    send_formula({"O", string'(8'hC1)});

    // hold off until every result is back
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (waiting == 0);
    repeat (5) @(posedge clk_i);

    // long text runs past the position limit
    longtxt = "H";
    repeat (258) longtxt = {longtxt, "1"};
    send_formula(longtxt);

    while (sent < 430) begin
      if ($urandom_range(0, 9) == 0) send_formula(noise_text());
      else if ($urandom_range(0, 9) == 0) send_formula({random_formula(), noise_text()});
      else send_formula(random_formula());
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    limit = 0;
    while (waiting != 0 && limit < 20000) begin
      @(posedge clk_i);
      limit++;
    end
    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && waiting == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
